[design/ldstat_pkg.sv]
// Shared types, constants and codes for the list statistics block.
`default_nettype none
package ldstat_pkg;

   localparam int MaxSamplesDefault   = 256;
   localparam int FractionBitsDefault = 16;
   localparam int QueueDepth          = 4;

   localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
   localparam logic signed [39:0] SUM_HI  = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0] SUM_LO  = 40'sh80_0000_0000;
   localparam logic [47:0]        VAR_TOP = 48'hFFFF_FFFF_FFFF;
   localparam logic [63:0]        PROD_POS_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]        PROD_NEG_SAT = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_SINGLE = 2'd2,
      STATUS_SAT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_EMPTY = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               last_sample;
      logic               empty_list;
   } req_item_type;

   typedef struct packed {
      logic [8:0]         element_count;
      logic signed [31:0] minimum;
      logic signed [31:0] maximum;
      logic signed [39:0] total;
      logic signed [63:0] product;
      logic signed [31:0] mean_value;
      logic [31:0]        spread;
      logic signed [31:0] midpoint;
      logic [47:0]        sample_variance;
      logic [1:0]         status;
   } rsp_item_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [31:0] value;
   } cmd_type;

endpackage
`default_nettype wire

[design/ldstat_if.sv]
// Valid/ready channel interfaces for sample items and result items.
`default_nettype none
interface ldstat_req_if import ldstat_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ldstat_rsp_if import ldstat_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/ldstat_front.sv]
// Front end: accept sample items, classify them and register the command.
`default_nettype none
module ldstat_front import ldstat_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ldstat_req_if.sink  req,
   output logic        cmd_valid,
   output cmd_type     cmd_data,
   input  wire logic   cmd_ready
);
   logic    stage_valid_ff;
   cmd_type stage_ff;
   cmd_type cmd_in;
   logic    take;

   assign req.ready = !stage_valid_ff || cmd_ready;
   assign take      = req.valid && req.ready;

   // empty marker wins over last marker
   always_comb begin
      cmd_in.value = req.data.sample_value;
      if (req.data.empty_list) begin
         cmd_in.kind = CMD_EMPTY;
      end else if (req.data.last_sample) begin
         cmd_in.kind = CMD_CLOSE;
      end else begin
         cmd_in.kind = CMD_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (take) begin
         stage_valid_ff <= 1'b1;
      end else if (cmd_ready) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= cmd_in;
      end
   end

   assign cmd_valid = stage_valid_ff;
   assign cmd_data  = stage_ff;
endmodule
`default_nettype wire

[design/ldstat_queue.sv]
// Short command queue between front end and back end.
`default_nettype none
module ldstat_queue import ldstat_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire cmd_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   output cmd_type      out_data,
   input  wire logic    out_ready
);
   localparam int PW = $clog2(QueueDepth);
   localparam int CW = $clog2(QueueDepth + 1);

   cmd_type         slot_ff [QueueDepth];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   fill_ff;
   logic            push;
   logic            pop;

   assign in_ready  = (fill_ff != CW'(QueueDepth));
   assign out_valid = (fill_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

[design/ldstat_div.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
`default_nettype none
module ldstat_div #(
   parameter int DW = 9
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [63:0]   dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [63:0]        quotient
);
   logic          busy_ff;
   logic          done_ff;
   logic [6:0]    step_ff;
   logic [DW-1:0] rem_ff;
   logic [63:0]   quo_ff;
   logic [DW-1:0] div_ff;
   logic [DW:0]   rem_sh;
   logic          fits;

   assign rem_sh = {rem_ff, quo_ff[63]};
   assign fits   = (rem_sh >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DW'(rem_sh - {1'b0, div_ff});
         end else begin
            rem_ff <= rem_sh[DW-1:0];
         end
         quo_ff <= {quo_ff[62:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[design/ldstat_back.sv]
// Back end: sample store, running statistics, variance pass and result register.
`default_nettype none
module ldstat_back import ldstat_pkg::*; #(
   parameter int MAX_SAMPLES   = MaxSamplesDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_ready,
   ldstat_rsp_if.source rsp
);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_SAMPLES);
   localparam logic [63:0]   PROD_ONE = 64'(1) << FRACTION_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_COMB, ST_ROUND,
      ST_MEAN_GO, ST_MEAN_WAIT, ST_VREAD, ST_VDIFF, ST_VSQ, ST_VACC,
      ST_VDIV_GO, ST_VDIV_WAIT, ST_EMIT
   } state_type;

   state_type          state_ff;
   logic signed [31:0] store_mem [MAX_SAMPLES];
   logic signed [31:0] rd_data_ff;
   logic [CW-1:0]      count_ff;
   logic signed [39:0] sum_ff;
   logic [63:0]        prod_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] max_ff;
   logic               sat_ff;
   logic               empty_ff;
   logic               close_ff;
   logic [63:0]        mp_ff;
   logic [31:0]        mx_ff;
   logic               neg_ff;
   logic [63:0]        lp_ff;
   logic [63:0]        mid_ff;
   logic [95:0]        full_ff;
   logic signed [31:0] mean_ff;
   logic [AW-1:0]      idx_ff;
   logic [32:0]        mag_ff;
   logic [63:0]        sq_ff;
   logic [63:0]        acc_ff;
   logic               acc_sat_ff;
   logic [47:0]        var_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;

   logic               pop;
   logic               store_wr;
   logic signed [40:0] sum_ext;
   logic [39:0]        sum_mag;
   logic [95:0]        q_shift;
   logic               rem_nz;
   logic [95:0]        q_round;
   logic               p_sat;
   logic [63:0]        p_next;
   logic signed [32:0] dev;
   logic [65:0]        sq_full;
   logic [64:0]        acc_sum;
   logic               div_start;
   logic [63:0]        div_dividend;
   logic [CW-1:0]      div_divisor;
   logic               div_done;
   logic [63:0]        div_q;
   logic signed [31:0] mean_sat;
   logic signed [32:0] mid_sum;
   logic signed [32:0] mid_adj;
   logic [CW+8:0]      cnt_ext;
   rsp_item_type       result;
   logic               emit_go;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign store_wr  = pop && (cmd_data.kind != CMD_EMPTY) && (count_ff < MAX_CNT);

   // running sum with clamp at 40 bits
   assign sum_ext = {sum_ff[39], sum_ff} + {{9{cmd_data.value[31]}}, cmd_data.value};
   assign sum_mag = sum_ff[39] ? 40'(-sum_ff) : 40'(sum_ff);

   // product rounding toward minus infinity, then saturation
   assign q_shift = full_ff >> FRACTION_BITS;
   assign rem_nz  = |(full_ff << (96 - FRACTION_BITS));
   assign q_round = q_shift + {95'd0, neg_ff && rem_nz};
   always_comb begin
      if (!neg_ff) begin
         p_sat  = |q_round[95:63];
         p_next = p_sat ? PROD_POS_SAT : q_round[63:0];
      end else begin
         p_sat  = (|q_round[95:64]) || (q_round[63] && (|q_round[62:0]));
         p_next = p_sat ? PROD_NEG_SAT : 64'(-q_round[63:0]);
      end
   end

   assign dev     = {rd_data_ff[31], rd_data_ff} - {mean_ff[31], mean_ff};
   assign sq_full = mag_ff * mag_ff;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, sq_ff};

   assign div_start    = (state_ff == ST_MEAN_GO) || (state_ff == ST_VDIV_GO);
   assign div_dividend = (state_ff == ST_MEAN_GO) ? {24'd0, sum_mag} : acc_ff;
   assign div_divisor  = (state_ff == ST_MEAN_GO) ? count_ff : CW'(count_ff - 1'b1);

   ldstat_div #(.DW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // signed mean from magnitude quotient, clamped to 32 bits
   always_comb begin
      if (!sum_ff[39]) begin
         mean_sat = (|div_q[63:31]) ? I32_MAX : 32'(div_q[31:0]);
      end else if ((|div_q[63:32]) || (div_q[31] && (|div_q[30:0]))) begin
         mean_sat = I32_MIN;
      end else begin
         mean_sat = 32'(-div_q[31:0]);
      end
   end

   assign mid_sum = {max_ff[31], max_ff} + {min_ff[31], min_ff};
   assign mid_adj = mid_sum + {32'd0, mid_sum[32] & mid_sum[0]};
   assign cnt_ext = {9'd0, count_ff};

   always_comb begin
      result.element_count   = cnt_ext[8:0];
      result.minimum         = min_ff;
      result.maximum         = max_ff;
      result.total           = sum_ff;
      result.product         = prod_ff;
      result.mean_value      = mean_ff;
      result.spread          = 32'(max_ff - min_ff);
      result.midpoint        = mid_adj[32:1];
      result.sample_variance = var_ff;
      if (empty_ff) begin
         result.product  = '0;
         result.spread   = '0;
         result.midpoint = '0;
         result.status   = STATUS_EMPTY;
      end else if (count_ff == CW'(1)) begin
         result.status = STATUS_SINGLE;
      end else if (sat_ff) begin
         result.status = STATUS_SAT;
      end else begin
         result.status = STATUS_OK;
      end
   end

   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[count_ff[AW-1:0]] <= cmd_data.value;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         prod_ff      <= PROD_ONE;
         min_ff       <= I32_MAX;
         max_ff       <= I32_MIN;
         sat_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= result;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  close_ff <= (cmd_data.kind == CMD_CLOSE);
                  if (cmd_data.kind == CMD_EMPTY) begin
                     empty_ff <= 1'b1;
                     count_ff <= '0;
                     sum_ff   <= '0;
                     min_ff   <= I32_MAX;
                     max_ff   <= I32_MIN;
                     mean_ff  <= '0;
                     var_ff   <= '0;
                     state_ff <= ST_EMIT;
                  end else if (store_wr) begin
                     count_ff <= count_ff + 1'b1;
                     if (sum_ext > 41'(SUM_HI)) begin
                        sum_ff <= SUM_HI;
                        sat_ff <= 1'b1;
                     end else if (sum_ext < 41'(SUM_LO)) begin
                        sum_ff <= SUM_LO;
                        sat_ff <= 1'b1;
                     end else begin
                        sum_ff <= sum_ext[39:0];
                     end
                     if (cmd_data.value < min_ff) begin
                        min_ff <= cmd_data.value;
                     end
                     if (cmd_data.value > max_ff) begin
                        max_ff <= cmd_data.value;
                     end
                     mp_ff    <= prod_ff[63] ? 64'(-prod_ff) : prod_ff;
                     mx_ff    <= cmd_data.value[31] ? 32'(-cmd_data.value)
                                                    : 32'(cmd_data.value);
                     neg_ff   <= prod_ff[63] ^ cmd_data.value[31];
                     state_ff <= ST_MUL_LO;
                  end else if (cmd_data.kind == CMD_CLOSE) begin
                     // store full: close without loading
                     state_ff <= ST_MEAN_GO;
                  end
               end
            end
            ST_MUL_LO: begin
               lp_ff    <= mp_ff[31:0] * mx_ff;
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               mid_ff   <= mp_ff[63:32] * mx_ff;
               state_ff <= ST_COMB;
            end
            ST_COMB: begin
               full_ff  <= {32'd0, lp_ff} + {mid_ff, 32'd0};
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               prod_ff <= p_next;
               if (p_sat) begin
                  sat_ff <= 1'b1;
               end
               state_ff <= close_ff ? ST_MEAN_GO : ST_IDLE;
            end
            ST_MEAN_GO: begin
               state_ff <= ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
               if (div_done) begin
                  mean_ff    <= mean_sat;
                  idx_ff     <= '0;
                  acc_ff     <= '0;
                  acc_sat_ff <= 1'b0;
                  var_ff     <= '0;
                  state_ff   <= (count_ff > CW'(1)) ? ST_VREAD : ST_EMIT;
               end
            end
            ST_VREAD: begin
               state_ff <= ST_VDIFF;
            end
            ST_VDIFF: begin
               mag_ff   <= dev[32] ? 33'(-dev) : 33'(dev);
               state_ff <= ST_VSQ;
            end
            ST_VSQ: begin
               sq_ff    <= 64'(sq_full >> FRACTION_BITS);
               state_ff <= ST_VACC;
            end
            ST_VACC: begin
               if (acc_sum[64] || acc_sat_ff) begin
                  acc_ff     <= '1;
                  acc_sat_ff <= 1'b1;
               end else begin
                  acc_ff <= acc_sum[63:0];
               end
               idx_ff <= idx_ff + 1'b1;
               if ((CW'(idx_ff) + 1'b1) == count_ff) begin
                  state_ff <= ST_VDIV_GO;
               end else begin
                  state_ff <= ST_VREAD;
               end
            end
            ST_VDIV_GO: begin
               state_ff <= ST_VDIV_WAIT;
            end
            ST_VDIV_WAIT: begin
               if (div_done) begin
                  if (acc_sat_ff || (|div_q[63:48])) begin
                     var_ff <= VAR_TOP;
                     sat_ff <= 1'b1;
                  end else begin
                     var_ff <= div_q[47:0];
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  // drop the list and return to reset values
                  count_ff <= '0;
                  sum_ff   <= '0;
                  prod_ff  <= PROD_ONE;
                  min_ff   <= I32_MAX;
                  max_ff   <= I32_MIN;
                  sat_ff   <= 1'b0;
                  empty_ff <= 1'b0;
                  close_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;
endmodule
`default_nettype wire

[design/list_descriptive_statistics_top.sv]
// Top level of the list descriptive statistics block.
// A sample passes the front-end register and the queue before it reaches the back end; a
// load is a store write plus a 4-step product unit, and the back end takes no new item
// until that unit is done. A closing item then runs the mean divide, a four-step variance
// pass over the N stored samples (skipped when N is 1) and the variance divide before its result.
// An empty marker goes straight to the result register. Synchronous reset clears all list
// state; the sample store is not cleared and only entries of the current list are read.
`default_nettype none
module list_descriptive_statistics_top import ldstat_pkg::*; #(
   parameter int MAX_SAMPLES   = MaxSamplesDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   ldstat_req_if.sink   req_chan,
   ldstat_rsp_if.source rsp_chan
);
   // classified commands from the front end into the queue
   logic    front_valid;
   cmd_type front_data;
   logic    front_ready;

   // queue head toward the back end
   logic    head_valid;
   cmd_type head_data;
   logic    head_ready;

   // Front: accept items and tag them as load, close or empty.
   ldstat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (front_valid),
      .cmd_data  (front_data),
      .cmd_ready (front_ready)
   );

   // Queue: decouple intake from the long close sequence.
   ldstat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .in_ready  (front_ready),
      .out_valid (head_valid),
      .out_data  (head_data),
      .out_ready (head_ready)
   );

   // Back: store, accumulate, run the variance pass and hold the result.
   ldstat_back #(
      .MAX_SAMPLES   (MAX_SAMPLES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd_data  (head_data),
      .cmd_ready (head_ready),
      .rsp       (rsp_chan)
   );
endmodule
`default_nettype wire
